// ===== design/averaged_bang_bang_positioner_macros.svh =====
// ---------------------------------------------------------------------------
// averaged_bang_bang_positioner_macros
// Assertion macros for the positioner. They compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef AVERAGED_BANG_BANG_POSITIONER_MACROS_SVH
`define AVERAGED_BANG_BANG_POSITIONER_MACROS_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define ABBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, during reset as well.
`define ABBP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABBP_ASSERT(lbl, prop, msg)
`define ABBP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/abbp_pkg.sv =====
// ---------------------------------------------------------------------------
// abbp_pkg
// Shared types and constants for the averaged bang-bang positioner.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package abbp_pkg;

	localparam int ADC_BITS         = 10;
	localparam int RETRY_W          = 16;
	localparam int SAMPLES_LOG2_DEF = 7;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Register reset values
	localparam logic [ADC_BITS-1:0] LOW_LIMIT_RST   = 10'd520;
	localparam logic [ADC_BITS-1:0] HIGH_LIMIT_RST  = 10'd1000;
	localparam logic [RETRY_W-1:0]  RETRY_LIMIT_RST = 16'd7650;

	// Register indexes (word address)
	typedef enum logic [1:0] {
		REG_LOW_LIMIT   = 2'd0,
		REG_HIGH_LIMIT  = 2'd1,
		REG_RETRY_LIMIT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_MEASURE = 2'd1,
		PH_MOVING  = 2'd2
	} phase_t;

	// Input item: func 0 = move command, 1 = ADC sample
	localparam logic FUNC_MOVE   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	typedef struct packed {
		logic                func;
		logic [ADC_BITS-1:0] target;
		logic [ADC_BITS-1:0] sample;
	} abbp_in_t;

	typedef struct packed {
		logic                drive_down;
		logic                drive_up;
		logic                busy_res;
		logic                done_res;
		logic                timed_out;
		logic [ADC_BITS-1:0] angle;
		logic [RETRY_W-1:0]  retries_left;
	} abbp_out_t;

endpackage

// ===== design/abbp_skid.sv =====
// ---------------------------------------------------------------------------
// abbp_skid
// Two-entry result buffer; keeps the input side flowing while a result waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module abbp_skid
	import abbp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  abbp_out_t push_data,
	output logic      space,
	output logic      out_valid,
	input  logic      out_ready,
	output abbp_out_t out_data
);

	logic [1:0] cnt_q;
	abbp_out_t  e0_q;
	abbp_out_t  e1_q;
	logic       pop;

	assign pop       = out_valid & out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = e0_q;
	assign space     = (cnt_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (push && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
			e0_q <= push_data;
		end else if (pop && cnt_q == 2'd2) begin
			e0_q <= e1_q;
		end
		if (push && cnt_q == 2'd1 && !pop) begin
			e1_q <= push_data;
		end
	end

endmodule

// ===== design/averaged_bang_bang_positioner.sv =====
// ---------------------------------------------------------------------------
// averaged_bang_bang_positioner
// Bang-bang position controller: clamps a goal, averages ADC blocks, drives
// up or down until the average crosses the goal or the retries run out.
// Results: each result is registered into the result buffer, behind any older ones, when its item is accepted.
// Throughput: one item per cycle while the two-entry result buffer has space; the state update
// for an item is a single add, compare and decrement, and input stalls while the buffer is full.
// Reset: arst_n clears the phase, counters and buffer; limits return to
// 520 / 1000 / 7650. No clearing pass, ready right after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "averaged_bang_bang_positioner_macros.svh"

module averaged_bang_bang_positioner
	import abbp_pkg::*;
#(
	parameter int SAMPLES_LOG2 = SAMPLES_LOG2_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  abbp_in_t           in_data,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output abbp_out_t          out_data,
	// configuration (APB-style)
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// Block accumulator is wide enough for 2^SAMPLES_LOG2 full-scale samples;
	// the sample counter can hold the block length itself.
	localparam int SUM_W = ADC_BITS + SAMPLES_LOG2;
	localparam int CNT_W = SAMPLES_LOG2 + 1;
	localparam logic [CNT_W-1:0] BLK_LEN = CNT_W'(1 << SAMPLES_LOG2);

	// -----------------------------------------------------------------------
	// Configuration registers
	// -----------------------------------------------------------------------
	logic [ADC_BITS-1:0] low_limit_q;
	logic [ADC_BITS-1:0] high_limit_q;
	logic [RETRY_W-1:0]  retry_limit_q;
	logic                cfg_wr;
	reg_idx_t            cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q   <= LOW_LIMIT_RST;
			high_limit_q  <= HIGH_LIMIT_RST;
			retry_limit_q <= RETRY_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_LOW_LIMIT:   low_limit_q   <= pwdata[ADC_BITS-1:0];
				REG_HIGH_LIMIT:  high_limit_q  <= pwdata[ADC_BITS-1:0];
				REG_RETRY_LIMIT: retry_limit_q <= pwdata[RETRY_W-1:0];
				default: ; // unmapped word, write dropped
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_LOW_LIMIT:   prdata = PDATA_W'(low_limit_q);
			REG_HIGH_LIMIT:  prdata = PDATA_W'(high_limit_q);
			REG_RETRY_LIMIT: prdata = PDATA_W'(retry_limit_q);
			default:         prdata = '0;
		endcase
	end

	// -----------------------------------------------------------------------
	// Controller state
	// -----------------------------------------------------------------------
	phase_t              phase_q, phase_d;
	logic                going_down_q, going_down_d;
	logic [ADC_BITS-1:0] goal_q, goal_d;
	logic [SUM_W-1:0]    sum_q, sum_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [RETRY_W-1:0]  retry_q, retry_d;
	logic [ADC_BITS-1:0] avg_q, avg_d;

	logic                acc;       // transaction on the input channel
	logic                is_move;
	logic                is_sample;
	logic [ADC_BITS-1:0] goal_lo;   // target raised to the low limit
	logic [ADC_BITS-1:0] goal_cl;   // then lowered to the high limit
	logic [SUM_W-1:0]    sum_inc;
	logic [CNT_W-1:0]    cnt_inc;
	logic                blk_end;   // this sample closes a block
	logic [ADC_BITS-1:0] blk_avg;
	logic [RETRY_W-1:0]  retry_dec;
	logic                reached;
	logic                done;
	logic                tmo;
	logic                buf_space;
	abbp_out_t           res;

	assign in_ready = buf_space;
	assign acc      = in_valid & in_ready;

	assign is_move   = (in_data.func == FUNC_MOVE)   && (phase_q == PH_IDLE);
	assign is_sample = (in_data.func == FUNC_SAMPLE) && (phase_q != PH_IDLE);

	assign goal_lo = (in_data.target < low_limit_q) ? low_limit_q : in_data.target;
	assign goal_cl = (goal_lo > high_limit_q) ? high_limit_q : goal_lo;

	assign sum_inc   = sum_q + SUM_W'(in_data.sample);
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign blk_end   = (cnt_inc == BLK_LEN);
	// Average is the block sum divided by the block size (a shift by SAMPLES_LOG2)
	assign blk_avg   = sum_inc[SAMPLES_LOG2 +: ADC_BITS];
	assign retry_dec = retry_q - RETRY_W'(1);
	// Stop condition: strictly past the goal in the direction of travel
	assign reached   = going_down_q ? (blk_avg < goal_q) : (blk_avg > goal_q);

	// The block ends a move on success, or when the decremented count hits zero
	assign done = is_sample && blk_end && (phase_q == PH_MOVING)
		&& (reached || retry_dec == '0);
	assign tmo  = done && !reached;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (is_move) phase_d = PH_MEASURE;
			end
			PH_MEASURE: begin
				if (is_sample && blk_end) phase_d = PH_MOVING;
			end
			PH_MOVING: begin
				if (done) phase_d = PH_IDLE;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// Datapath next values
	always_comb begin
		going_down_d = going_down_q;
		goal_d       = goal_q;
		sum_d        = sum_q;
		cnt_d        = cnt_q;
		retry_d      = retry_q;
		avg_d        = avg_q;
		if (is_move) begin
			goal_d  = goal_cl;
			sum_d   = '0;
			cnt_d   = '0;
			retry_d = retry_limit_q;
		end else if (is_sample) begin
			if (blk_end) begin
				avg_d = blk_avg;
				sum_d = '0;
				cnt_d = '0;
				if (phase_q == PH_MEASURE) begin
					// first average picks the direction
					going_down_d = (blk_avg > goal_q);
				end else if (!reached) begin
					retry_d = retry_dec;
				end
			end else begin
				sum_d = sum_inc;
				cnt_d = cnt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			going_down_q <= 1'b0;
			goal_q       <= '0;
			sum_q        <= '0;
			cnt_q        <= '0;
			retry_q      <= '0;
			avg_q        <= '0;
		end else if (acc) begin
			phase_q      <= phase_d;
			going_down_q <= going_down_d;
			goal_q       <= goal_d;
			sum_q        <= sum_d;
			cnt_q        <= cnt_d;
			retry_q      <= retry_d;
			avg_q        <= avg_d;
		end
	end

	// Result of this transaction, taken from the post-update state
	always_comb begin
		res.drive_down   = (phase_d == PH_MOVING) &&  going_down_d;
		res.drive_up     = (phase_d == PH_MOVING) && !going_down_d;
		res.busy_res     = (phase_d != PH_IDLE);
		res.done_res     = done;
		res.timed_out    = tmo;
		res.angle        = avg_d;
		res.retries_left = retry_d;
	end

	abbp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.push_data (res),
		.space     (buf_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// -----------------------------------------------------------------------
	// Assertions
	// -----------------------------------------------------------------------
	`ABBP_ASSERT(a_cnt_in_block, cnt_q < BLK_LEN, "sample count ran past block length")
	`ABBP_ASSERT(a_done_to_idle, (acc && done) |=> (phase_q == PH_IDLE), "move ended but not idle")
	`ABBP_ASSERT_ALWAYS(a_tmo_needs_done, !(tmo && !done), "timeout flagged without done")
	`ABBP_ASSERT(a_one_drive, !(res.drive_down && res.drive_up), "both drives on")

endmodule

// ===== test/abbp_status_checker.sv =====
// ---------------------------------------------------------------------------
// abbp_status_checker
// Watches the positioner's channels and configuration bus, predicts each
// status transaction from its own model of the move sequencer and compares
// field by field against what the block returns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module abbp_status_checker
	import abbp_pkg::*;
#(
	parameter int SAMPLES_LOG2 = SAMPLES_LOG2_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  abbp_in_t           in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  abbp_out_t          out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 mismatches,
	output int                 outstanding
);

	localparam int BLOCK_LEN = 1 << SAMPLES_LOG2;

	// register copies
	logic [ADC_BITS-1:0] low_lim;
	logic [ADC_BITS-1:0] high_lim;
	logic [RETRY_W-1:0]  retry_lim;

	// sequencer state
	phase_t              ph;
	logic                heading_down;
	logic [ADC_BITS-1:0] goal;
	logic [31:0]         acc;
	int                  taken;
	logic [RETRY_W-1:0]  retries;
	logic [ADC_BITS-1:0] last_avg;

	abbp_out_t expected_status[$];
	abbp_out_t oldest;

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("[%0t] %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	task automatic advance_positioner(input abbp_in_t item);
		abbp_out_t           st;
		logic [ADC_BITS-1:0] avg;
		logic                finished;
		logic                expired;
		finished = 1'b0;
		expired  = 1'b0;
		if (item.func == FUNC_MOVE) begin
			// commands while a move is running are dropped
			if (ph == PH_IDLE) begin
				goal = item.target;
				if (goal < low_lim)
					goal = low_lim;
				if (goal > high_lim)
					goal = high_lim;
				acc     = '0;
				taken   = 0;
				retries = retry_lim;
				ph      = PH_MEASURE;
			end
		end else if (ph != PH_IDLE) begin
			acc += item.sample;
			taken++;
			if (taken == BLOCK_LEN) begin
				avg      = ADC_BITS'(acc >> SAMPLES_LOG2);
				last_avg = avg;
				acc      = '0;
				taken    = 0;
				if (ph == PH_MEASURE) begin
					heading_down = avg > goal;
					ph           = PH_MOVING;
				end else begin
					finished = heading_down ? (avg < goal) : (avg > goal);
					if (!finished) begin
						// zero limit wraps here, so it behaves as 65536
						retries--;
						expired  = (retries == '0);
						finished = expired;
					end
					if (finished)
						ph = PH_IDLE;
				end
			end
		end
		st.drive_down   = (ph == PH_MOVING) && heading_down;
		st.drive_up     = (ph == PH_MOVING) && !heading_down;
		st.busy_res     = (ph != PH_IDLE);
		st.done_res     = finished;
		st.timed_out    = expired;
		st.angle        = last_avg;
		st.retries_left = retries;
		expected_status.push_back(st);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_lim      = LOW_LIMIT_RST;
			high_lim     = HIGH_LIMIT_RST;
			retry_lim    = RETRY_LIMIT_RST;
			ph           = PH_IDLE;
			heading_down = 1'b0;
			goal         = '0;
			acc          = '0;
			taken        = 0;
			retries      = '0;
			last_avg     = '0;
			expected_status.delete();
			outstanding  = 0;
		end else begin
			// results are registered after their item, so compare first
			if (out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					report("status transaction with no prediction waiting");
				end else begin
					oldest = expected_status.pop_front();
					compare_field("drive_down", out_data.drive_down, oldest.drive_down);
					compare_field("drive_up", out_data.drive_up, oldest.drive_up);
					compare_field("busy_res", out_data.busy_res, oldest.busy_res);
					compare_field("done_res", out_data.done_res, oldest.done_res);
					compare_field("timed_out", out_data.timed_out, oldest.timed_out);
					compare_field("angle", out_data.angle, oldest.angle);
					compare_field("retries_left", out_data.retries_left,
						oldest.retries_left);
				end
			end
			if (in_valid && in_ready)
				advance_positioner(in_data);
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:2]))
					REG_LOW_LIMIT:   low_lim   = pwdata[ADC_BITS-1:0];
					REG_HIGH_LIMIT:  high_lim  = pwdata[ADC_BITS-1:0];
					REG_RETRY_LIMIT: retry_lim = pwdata[RETRY_W-1:0];
					default: ;
				endcase
			end
			outstanding = expected_status.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the averaged bang-bang positioner. Drives move
// commands and ADC sample blocks through the input channel, reprograms the
// limits between phases and throttles both channels; the status checker
// beside the block predicts and compares every result transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import abbp_pkg::*;

	// Default averaging block of 128 samples; the stimulus is planned in
	// whole blocks so the item budget covers every kind of move end.
	localparam int AVG_LOG2     = SAMPLES_LOG2_DEF;
	localparam int BLOCK_LEN    = 1 << AVG_LOG2;
	localparam int ADC_MAX      = (1 << ADC_BITS) - 1;
	localparam int ITEM_TARGET  = 1550;
	localparam int HOLD_CYCLES  = 120;
	localparam int LIMIT_CYCLES = 1000000;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	abbp_in_t           in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	abbp_out_t          out_data;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int mismatches;
	int outstanding;

	// shared between the sender and the result sink
	bit steady;        // no idling on either side while set
	bit hold_off_req;  // asks the sink for one long stall
	int items_sent;

	averaged_bang_bang_positioner #(
		.SAMPLES_LOG2(AVG_LOG2)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	abbp_status_checker #(
		.SAMPLES_LOG2(AVG_LOG2)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sender gap: mostly back to back, some short pauses, the odd long one.
	function automatic int gap_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// Position with the rails weighted up, so clamps and stuck goals occur.
	function automatic int pick_position();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return ADC_MAX;
		return $urandom_range(0, ADC_MAX);
	endfunction

	// Offers one input transaction and returns at the falling edge after it
	// was taken. The unused field carries noise so every bit gets toggled.
	task automatic push_item(input logic func, input int val);
		abbp_in_t item;
		int       gap;
		item.func   = func;
		item.target = (func == FUNC_MOVE) ? ADC_BITS'(val) : ADC_BITS'($urandom);
		item.sample = (func == FUNC_SAMPLE) ? ADC_BITS'(val) : ADC_BITS'($urandom);
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	// One averaging block around lvl, jittered by up to +/- spread.
	task automatic sample_block(input int lvl, input int spread);
		int v;
		repeat (BLOCK_LEN) begin
			v = lvl + int'($urandom_range(0, 2 * spread)) - spread;
			if (v < 0)
				v = 0;
			else if (v > ADC_MAX)
				v = ADC_MAX;
			push_item(FUNC_SAMPLE, v);
		end
	endtask

	// Stops offering and waits for every predicted transaction to come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Setup phase, access phase, then a quiet phase with psel low so back-to-back writes
	// never retarget psel within a single step. Upper bits carry junk.
	task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val,
			input int width);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= PDATA_W'(({$urandom} << width) | val);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_limits(input int lo, input int hi, input int rl);
		apb_write(REG_LOW_LIMIT, PDATA_W'(lo), ADC_BITS);
		apb_write(REG_HIGH_LIMIT, PDATA_W'(hi), ADC_BITS);
		apb_write(REG_RETRY_LIMIT, PDATA_W'(rl), RETRY_W);
	endtask

	// Result sink: random ready with occasional stalls, one long hold-off on
	// request, and always ready during steady stretches.
	initial begin : result_sink
		int r;
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = HOLD_CYCLES - 1;
				out_ready   <= 1'b0;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3)
					stall_left = $urandom_range(8, 40);
				out_ready <= (r >= 25);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		int lo;
		int hi;
		int rl;
		int r;
		int spread;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset limits 520 / 1000: sample while idle is dropped, low target
		// raised to the low limit, command while busy dropped, high first
		// average sends it down, low average ends it.
		push_item(FUNC_SAMPLE, ADC_MAX);
		push_item(FUNC_MOVE, 0);
		push_item(FUNC_MOVE, ADC_MAX);
		sample_block(ADC_MAX, 0);
		sample_block(0, 0);

		// High target lowered to 1000, upward move; an average equal to the
		// goal costs one retry, a full-scale average ends it. The sink holds
		// off for a long stretch while the sender keeps going, so the result
		// buffer fills and input stalls.
		push_item(FUNC_MOVE, ADC_MAX);
		hold_off_req = 1'b1;
		sample_block(0, 4);
		sample_block(1000, 0);
		sample_block(ADC_MAX, 0);
		drain();

		// Widest limits, single retry: a goal on the bottom rail can only
		// time out. Steady stretch with no idling on either side.
		steady = 1'b1;
		program_limits(0, ADC_MAX, 1);
		push_item(FUNC_MOVE, 0);
		sample_block(512, 300);
		sample_block(0, 0);
		drain();
		steady = 1'b0;

		// Crossed limits: goal is always the high limit (300 here). Retry
		// limit of zero wraps to 65536, so a miss leaves 65535; a low block
		// then ends the move.
		program_limits(700, 300, 0);
		push_item(FUNC_MOVE, pick_position());
		sample_block(ADC_MAX, 0);
		sample_block(500, 20);
		sample_block(0, 0);
		drain();

		// Random limits, stray commands, stray samples and noisy blocks until
		// the item budget is spent.
		while (items_sent + BLOCK_LEN <= ITEM_TARGET) begin
			steady = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 9);
			if (r < 2) begin
				drain();
				lo = pick_position();
				hi = pick_position();
				rl = $urandom_range(0, 3);
				program_limits(lo, hi, rl);
			end else if (r < 4) begin
				push_item(FUNC_MOVE, pick_position());
			end else if (r < 5) begin
				repeat ($urandom_range(1, 3))
					push_item(FUNC_SAMPLE, pick_position());
			end else begin
				spread = ($urandom_range(0, 4) == 0) ? 300 : int'($urandom_range(0, 6));
				sample_block(pick_position(), spread);
			end
		end
		steady = 1'b0;

		drain();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== averaged_bang_bang_positioner.f =====
+incdir+design
design/abbp_pkg.sv
design/abbp_skid.sv
design/averaged_bang_bang_positioner.sv
test/abbp_status_checker.sv
test/tb.sv
